@@ rtl/gaps_pkg.sv @@
package gaps_pkg;

    localparam int X_BITS    = 6;
    localparam int MAP_W     = 1 << X_BITS;
    localparam int MAP_H     = 64;
    localparam int CELLS     = MAP_W * MAP_H;
    localparam int CELL_BITS = $clog2(CELLS);
    localparam int CNT_BITS  = CELL_BITS + 1;
    localparam int SEQ_BITS  = CELL_BITS + 4;
    localparam int COST_BITS = 24;
    localparam int FRAC_BITS = 8;
    localparam int H_BITS    = 16;
    localparam int EXT_BITS  = 7;

    localparam logic [COST_BITS-1:0] COST_MAX  = {COST_BITS{1'b1}};
    localparam logic [COST_BITS-1:0] STEP_ONE  = COST_BITS'(1 << FRAC_BITS);
    localparam logic [COST_BITS-1:0] STEP_DIAG = COST_BITS'(362);
    localparam logic [EXT_BITS-1:0]  EXT_MAX   = EXT_BITS'(MAP_W);

    localparam logic [1:0] ST_NEW    = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_CLOSED = 2'd2;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_MARK   = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_OFF   = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam int OP_BITS = 5;
    localparam logic [OP_BITS-1:0] OP_NONE   = 5'd0;
    localparam logic [OP_BITS-1:0] OP_LATCH  = 5'd1;
    localparam logic [OP_BITS-1:0] OP_CLR    = 5'd2;
    localparam logic [OP_BITS-1:0] OP_MARK   = 5'd3;
    localparam logic [OP_BITS-1:0] OP_SFAIL  = 5'd4;
    localparam logic [OP_BITS-1:0] OP_SINIT  = 5'd5;
    localparam logic [OP_BITS-1:0] OP_SCLR   = 5'd6;
    localparam logic [OP_BITS-1:0] OP_START  = 5'd7;
    localparam logic [OP_BITS-1:0] OP_NODE0  = 5'd8;
    localparam logic [OP_BITS-1:0] OP_NODE   = 5'd9;
    localparam logic [OP_BITS-1:0] OP_PUSH   = 5'd10;
    localparam logic [OP_BITS-1:0] OP_SCAN0  = 5'd11;
    localparam logic [OP_BITS-1:0] OP_SCAN   = 5'd12;
    localparam logic [OP_BITS-1:0] OP_POPMV  = 5'd13;
    localparam logic [OP_BITS-1:0] OP_POPG   = 5'd14;
    localparam logic [OP_BITS-1:0] OP_NBIS   = 5'd15;
    localparam logic [OP_BITS-1:0] OP_NEXT   = 5'd16;
    localparam logic [OP_BITS-1:0] OP_WSTORE = 5'd17;
    localparam logic [OP_BITS-1:0] OP_WPAR   = 5'd18;
    localparam logic [OP_BITS-1:0] OP_RDOUT  = 5'd19;
    localparam logic [OP_BITS-1:0] OP_RDFAIL = 5'd20;
    localparam logic [OP_BITS-1:0] OP_FINISH = 5'd21;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic [5:0]  goal_x;
        logic [5:0]  goal_y;
        logic [11:0] step_number;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [12:0] path_cells;
        logic [23:0] path_cost;
        logic [5:0]  step_x;
        logic [5:0]  step_y;
    } result_t;

    // up to eight inserts or re-keys per cell in one search
    typedef struct packed {
        logic [COST_BITS-1:0] key;
        logic [SEQ_BITS-1:0]  seq;
        logic [CELL_BITS-1:0] node;
    } entry_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       cell_on;
        logic       goal_on;
        logic       k_ok;
        logic       sweep_last;
        logic       open_empty;
        logic       scan_end;
        logic       h_done;
        logic       nb_in;
        logic       nb_skip;
        logic       is_target;
        logic       last_dir;
        logic       at_start;
        logic       walk_end;
    } dp_status_t;

    function automatic logic [1:0] dir_dx(input logic [2:0] d);
        case (d)
            3'd0, 3'd1, 3'd2: dir_dx = 2'b11;
            3'd3, 3'd4:       dir_dx = 2'b00;
            default:          dir_dx = 2'b01;
        endcase
    endfunction

    function automatic logic [1:0] dir_dy(input logic [2:0] d);
        case (d)
            3'd0, 3'd3, 3'd5: dir_dy = 2'b11;
            3'd1, 3'd6:       dir_dy = 2'b00;
            default:          dir_dy = 2'b01;
        endcase
    endfunction

    function automatic logic dir_diag(input logic [2:0] d);
        dir_diag = (d == 3'd0) || (d == 3'd2) || (d == 3'd5) || (d == 3'd7);
    endfunction

endpackage

@@ rtl/gaps_isqrt.sv @@
module gaps_isqrt
    import gaps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [31:0]       operand,
    output logic              running,
    output logic [H_BITS-1:0] root
);

    logic [31:0] v_reg, v_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] bit_reg, bit_next;
    logic        run_reg, run_next;
    logic [31:0] trial;

    assign trial = r_reg + bit_reg;

    always_comb
    begin
        v_next   = v_reg;
        r_next   = r_reg;
        bit_next = bit_reg;
        run_next = run_reg;
        if (go)
        begin
            v_next   = operand;
            r_next   = '0;
            bit_next = 32'h4000_0000;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= 1'b0;
        else
            run_reg <= run_next;
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign running = run_reg;
    assign root    = r_reg[H_BITS-1:0];

endmodule

@@ rtl/gaps_dp.sv @@
module gaps_dp
    import gaps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [OP_BITS-1:0] op,
    input  request_t           request,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data,
    output dp_status_t         flags,
    output result_t            result
);

    logic [EXT_BITS-1:0]  width_reg, height_reg, w_eff, h_eff;
    request_t             req_reg;
    logic [CELL_BITS-1:0] cnt_reg;
    logic [1:0]           stat_reg;
    logic [5:0]           sx_reg, sy_reg;
    logic                 found_reg;
    logic [CNT_BITS-1:0]  path_count_reg;
    logic [COST_BITS-1:0] last_cost_reg;
    logic [CNT_BITS-1:0]  open_count_reg, scan_idx_reg;
    logic [SEQ_BITS-1:0]  seq_reg;
    logic                 cmp_valid_reg;
    logic [CELL_BITS-1:0] cmp_idx_reg, best_idx_reg;
    entry_t               best_reg, last_entry_reg;
    logic [CELL_BITS-1:0] cur_reg, nc_reg, walk_reg;
    logic [COST_BITS-1:0] gcur_reg, gnew_reg;
    logic [2:0]           dir_reg;
    logic [12:0]          sumsq_reg;
    logic                 was_new_reg;
    result_t              result_reg;

    logic                 obs_mem [CELLS];
    logic [1:0]           st_mem [CELLS];
    logic [COST_BITS-1:0] cost_mem [CELLS];
    logic [2:0]           par_mem [CELLS];
    logic [CELL_BITS-1:0] slot_mem [CELLS];
    entry_t               heap_mem [CELLS];
    logic [CELL_BITS-1:0] path_mem [CELLS];

    logic                 obs_q;
    logic [1:0]           st_q;
    logic [COST_BITS-1:0] cost_q;
    logic [2:0]           par_q;
    logic [CELL_BITS-1:0] slot_q;
    entry_t               heap_q;
    logic [CELL_BITS-1:0] path_q;

    logic                 obs_we, obs_wd;
    logic [CELL_BITS-1:0] obs_wa;
    logic                 st_we;
    logic [1:0]           st_wd;
    logic [CELL_BITS-1:0] st_wa;
    logic                 heap_we;
    logic [CELL_BITS-1:0] heap_wa;
    entry_t               heap_wd;
    logic                 slot_we;
    logic [CELL_BITS-1:0] slot_wa, slot_wd;
    logic [CELL_BITS-1:0] cost_ra, path_ra;

    logic [1:0]           ddx, ddy, pdx, pdy;
    logic [7:0]           nx, ny, px, py;
    logic [CELL_BITS-1:0] nb_cell, start_cell, goal_cell;
    logic [5:0]           hx, hy, adx, ady;
    logic [12:0]          sumsq;
    logic [COST_BITS:0]   gsum, fsum;
    logic [COST_BITS-1:0] gsat, fsat;
    logic [CNT_BITS-1:0]  open_last, rd_idx;
    logic                 better;
    logic                 sq_go, sq_run;
    logic [H_BITS-1:0]    sq_root;

    assign w_eff = (width_reg > EXT_MAX) ? EXT_MAX : width_reg;
    assign h_eff = (height_reg > EXT_MAX) ? EXT_MAX : height_reg;

    assign start_cell = {req_reg.cell_y, req_reg.cell_x};
    assign goal_cell  = {req_reg.goal_y, req_reg.goal_x};

    assign ddx     = dir_dx(dir_reg);
    assign ddy     = dir_dy(dir_reg);
    assign nx      = {2'b00, cur_reg[X_BITS-1:0]} + {{6{ddx[1]}}, ddx};
    assign ny      = {2'b00, cur_reg[CELL_BITS-1:X_BITS]} + {{6{ddy[1]}}, ddy};
    assign nb_cell = {ny[5:0], nx[5:0]};

    assign pdx = dir_dx(par_q);
    assign pdy = dir_dy(par_q);
    assign px  = {2'b00, walk_reg[X_BITS-1:0]} - {{6{pdx[1]}}, pdx};
    assign py  = {2'b00, walk_reg[CELL_BITS-1:X_BITS]} - {{6{pdy[1]}}, pdy};

    assign hx    = (op == OP_START) ? req_reg.cell_x : nx[5:0];
    assign hy    = (op == OP_START) ? req_reg.cell_y : ny[5:0];
    assign adx   = (hx >= req_reg.goal_x) ? hx - req_reg.goal_x : req_reg.goal_x - hx;
    assign ady   = (hy >= req_reg.goal_y) ? hy - req_reg.goal_y : req_reg.goal_y - hy;
    assign sumsq = (13'(adx) * 13'(adx)) + (13'(ady) * 13'(ady));

    assign gsum = {1'b0, gcur_reg} + {1'b0, dir_diag(dir_reg) ? STEP_DIAG : STEP_ONE};
    assign gsat = gsum[COST_BITS] ? COST_MAX : gsum[COST_BITS-1:0];
    assign fsum = {1'b0, gnew_reg} + (COST_BITS+1)'(sq_root);
    assign fsat = fsum[COST_BITS] ? COST_MAX : fsum[COST_BITS-1:0];

    assign open_last = open_count_reg - 1'b1;
    assign rd_idx    = path_count_reg - 1'b1 - {1'b0, req_reg.step_number};
    assign path_ra   = rd_idx[CELL_BITS-1:0];
    assign cost_ra   = (op == OP_POPMV) ? best_reg.node : nb_cell;

    assign better = (cmp_idx_reg == '0) || (heap_q.key < best_reg.key) ||
                    ((heap_q.key == best_reg.key) && (heap_q.seq < best_reg.seq));

    assign sq_go = (op == OP_NODE) || (op == OP_NODE0);

    gaps_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (sq_go),
        .operand ({3'b000, sumsq_reg, 16'h0000}),
        .running (sq_run),
        .root    (sq_root)
    );

    always_comb
    begin
        obs_we  = 1'b0;
        obs_wa  = cnt_reg;
        obs_wd  = 1'b0;
        st_we   = 1'b0;
        st_wa   = cnt_reg;
        st_wd   = ST_NEW;
        heap_we = 1'b0;
        heap_wa = best_idx_reg;
        heap_wd = last_entry_reg;
        slot_we = 1'b0;
        slot_wa = last_entry_reg.node;
        slot_wd = best_idx_reg;
        case (op)
            OP_CLR:
                obs_we = 1'b1;
            OP_MARK:
            begin
                obs_we = flags.cell_on;
                obs_wa = start_cell;
                obs_wd = 1'b1;
            end
            OP_SCLR:
                st_we = 1'b1;
            OP_POPMV:
            begin
                st_we   = 1'b1;
                st_wa   = best_reg.node;
                st_wd   = ST_CLOSED;
                heap_we = ({1'b0, best_idx_reg} != open_last);
                slot_we = heap_we;
            end
            OP_PUSH:
            begin
                st_wa   = nc_reg;
                st_wd   = ST_OPEN;
                heap_wd = '{key: fsat, seq: seq_reg, node: nc_reg};
                slot_wa = nc_reg;
                slot_wd = open_count_reg[CELL_BITS-1:0];
                if (was_new_reg)
                begin
                    st_we   = 1'b1;
                    heap_we = !open_count_reg[CELL_BITS];
                    heap_wa = open_count_reg[CELL_BITS-1:0];
                    slot_we = heap_we;
                end
                else
                begin
                    heap_we = 1'b1;
                    heap_wa = slot_q;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (obs_we)
            obs_mem[obs_wa] <= obs_wd;
        obs_q <= obs_mem[nb_cell];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            st_mem[st_wa] <= st_wd;
        st_q <= st_mem[nb_cell];
    end

    always_ff @(posedge clk)
    begin
        if (sq_go)
            cost_mem[nc_reg] <= gnew_reg;
        cost_q <= cost_mem[cost_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sq_go)
            par_mem[nc_reg] <= dir_reg;
        par_q <= par_mem[walk_reg];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_wa] <= slot_wd;
        slot_q <= slot_mem[nc_reg];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
            heap_mem[heap_wa] <= heap_wd;
        heap_q <= heap_mem[scan_idx_reg[CELL_BITS-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_WSTORE)
            path_mem[path_count_reg[CELL_BITS-1:0]] <= walk_reg;
        path_q <= path_mem[path_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= EXT_MAX;
            height_reg     <= EXT_MAX;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            path_count_reg <= '0;
            last_cost_reg  <= '0;
            open_count_reg <= '0;
            seq_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write && !cfg_index)
                width_reg <= cfg_data;
            if (cfg_write && cfg_index)
                height_reg <= cfg_data;
            cmp_valid_reg <= (op == OP_SCAN);
            case (op)
                OP_LATCH:
                    cnt_reg <= '0;
                OP_CLR, OP_SCLR:
                    cnt_reg <= cnt_reg + 1'b1;
                OP_SINIT:
                begin
                    cnt_reg        <= '0;
                    found_reg      <= 1'b0;
                    path_count_reg <= '0;
                    last_cost_reg  <= '0;
                    open_count_reg <= '0;
                    seq_reg        <= '0;
                end
                OP_PUSH:
                begin
                    if (!was_new_reg)
                        seq_reg <= seq_reg + 1'b1;
                    else if (!open_count_reg[CELL_BITS])
                    begin
                        seq_reg        <= seq_reg + 1'b1;
                        open_count_reg <= open_count_reg + 1'b1;
                    end
                end
                OP_POPMV:
                    open_count_reg <= open_last;
                OP_POPG:
                begin
                    if (flags.is_target)
                    begin
                        found_reg     <= 1'b1;
                        last_cost_reg <= cost_q;
                    end
                end
                OP_WSTORE:
                    path_count_reg <= path_count_reg + 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_valid_reg)
        begin
            if (better)
            begin
                best_reg     <= heap_q;
                best_idx_reg <= cmp_idx_reg;
            end
            if ({1'b0, cmp_idx_reg} == open_last)
                last_entry_reg <= heap_q;
        end
        case (op)
            OP_LATCH:
            begin
                req_reg  <= request;
                stat_reg <= STAT_OK;
                sx_reg   <= '0;
                sy_reg   <= '0;
            end
            OP_MARK:
                if (!flags.cell_on)
                    stat_reg <= STAT_OFF;
            OP_SFAIL:
                stat_reg <= STAT_OFF;
            OP_RDFAIL:
                stat_reg <= STAT_RANGE;
            OP_RDOUT:
            begin
                sx_reg <= path_q[X_BITS-1:0];
                sy_reg <= path_q[CELL_BITS-1:X_BITS];
            end
            OP_START:
            begin
                nc_reg    <= start_cell;
                gnew_reg  <= '0;
                sumsq_reg <= sumsq;
            end
            OP_NODE0:
                was_new_reg <= 1'b1;
            OP_NODE:
                was_new_reg <= (st_q == ST_NEW);
            OP_SCAN0:
                scan_idx_reg <= '0;
            OP_SCAN:
            begin
                cmp_idx_reg  <= scan_idx_reg[CELL_BITS-1:0];
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            OP_POPMV:
            begin
                cur_reg <= best_reg.node;
                dir_reg <= '0;
            end
            OP_POPG:
            begin
                gcur_reg <= cost_q;
                walk_reg <= goal_cell;
            end
            OP_NBIS:
            begin
                nc_reg    <= nb_cell;
                gnew_reg  <= gsat;
                sumsq_reg <= sumsq;
            end
            OP_NEXT:
                dir_reg <= dir_reg + 1'b1;
            OP_WPAR:
                walk_reg <= {py[5:0], px[5:0]};
            OP_FINISH:
                result_reg <= '{status: stat_reg, found: found_reg,
                                path_cells: path_count_reg, path_cost: last_cost_reg,
                                step_x: sx_reg, step_y: sy_reg};
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        flags.cmd        = req_reg.command;
        flags.cell_on    = ({1'b0, req_reg.cell_x} < w_eff) && ({1'b0, req_reg.cell_y} < h_eff);
        flags.goal_on    = ({1'b0, req_reg.goal_x} < w_eff) && ({1'b0, req_reg.goal_y} < h_eff);
        flags.k_ok       = ({1'b0, req_reg.step_number} < path_count_reg);
        flags.sweep_last = (cnt_reg == CELL_BITS'(CELLS - 1));
        flags.open_empty = (open_count_reg == '0);
        flags.scan_end   = (scan_idx_reg == open_count_reg);
        flags.h_done     = !sq_run;
        flags.nb_in      = !nx[7] && !ny[7] && (nx[6:0] < w_eff) && (ny[6:0] < h_eff);
        flags.nb_skip    = obs_q || (st_q == ST_CLOSED) ||
                           ((st_q == ST_OPEN) && (gnew_reg >= cost_q));
        flags.is_target  = (cur_reg == goal_cell);
        flags.last_dir   = (dir_reg == 3'd7);
        flags.at_start   = (walk_reg == start_cell);
        flags.walk_end   = (px[7:6] != 2'b00) || (py[7:6] != 2'b00) ||
                           (path_count_reg == CNT_BITS'(CELLS));
    end

    assign result = result_reg;

endmodule

@@ rtl/gaps_ctrl.sv @@
module gaps_ctrl
    import gaps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  dp_status_t         flags,
    output logic [OP_BITS-1:0] op,
    output logic               busy,
    output logic               done
);

    localparam logic [4:0] S_RCLR  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_CLR   = 5'd3;
    localparam logic [4:0] S_SCLR  = 5'd4;
    localparam logic [4:0] S_START = 5'd5;
    localparam logic [4:0] S_NODE0 = 5'd6;
    localparam logic [4:0] S_HW0   = 5'd7;
    localparam logic [4:0] S_PUSH0 = 5'd8;
    localparam logic [4:0] S_POPI  = 5'd9;
    localparam logic [4:0] S_SCAN  = 5'd10;
    localparam logic [4:0] S_POPMV = 5'd11;
    localparam logic [4:0] S_POPG  = 5'd12;
    localparam logic [4:0] S_NBIS  = 5'd13;
    localparam logic [4:0] S_NBEV  = 5'd14;
    localparam logic [4:0] S_HW    = 5'd15;
    localparam logic [4:0] S_PUSH  = 5'd16;
    localparam logic [4:0] S_NEXT  = 5'd17;
    localparam logic [4:0] S_WST   = 5'd18;
    localparam logic [4:0] S_WPAR  = 5'd19;
    localparam logic [4:0] S_RDW   = 5'd20;
    localparam logic [4:0] S_DONE  = 5'd21;

    logic [4:0] state_reg, state_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_RCLR:
            begin
                op = OP_CLR;
                if (flags.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
                if (start)
                begin
                    op         = OP_LATCH;
                    state_next = S_DISP;
                end
            S_DISP:
                case (flags.cmd)
                    CMD_CLEAR:
                        state_next = S_CLR;
                    CMD_MARK:
                    begin
                        op         = OP_MARK;
                        state_next = S_DONE;
                    end
                    CMD_SEARCH:
                        if (flags.cell_on && flags.goal_on)
                        begin
                            op         = OP_SINIT;
                            state_next = S_SCLR;
                        end
                        else
                        begin
                            op         = OP_SFAIL;
                            state_next = S_DONE;
                        end
                    default:
                        if (flags.k_ok)
                            state_next = S_RDW;
                        else
                        begin
                            op         = OP_RDFAIL;
                            state_next = S_DONE;
                        end
                endcase
            S_CLR:
            begin
                op = OP_CLR;
                if (flags.sweep_last)
                    state_next = S_DONE;
            end
            S_SCLR:
            begin
                op = OP_SCLR;
                if (flags.sweep_last)
                    state_next = S_START;
            end
            S_START:
            begin
                op         = OP_START;
                state_next = S_NODE0;
            end
            S_NODE0:
            begin
                op         = OP_NODE0;
                state_next = S_HW0;
            end
            S_HW0:
                if (flags.h_done)
                    state_next = S_PUSH0;
            S_PUSH0:
            begin
                op         = OP_PUSH;
                state_next = S_POPI;
            end
            S_POPI:
                if (flags.open_empty)
                    state_next = S_DONE;
                else
                begin
                    op         = OP_SCAN0;
                    state_next = S_SCAN;
                end
            S_SCAN:
                if (flags.scan_end)
                    state_next = S_POPMV;
                else
                    op = OP_SCAN;
            S_POPMV:
            begin
                op         = OP_POPMV;
                state_next = S_POPG;
            end
            S_POPG:
            begin
                op         = OP_POPG;
                state_next = flags.is_target ? S_WST : S_NBIS;
            end
            S_NBIS:
            begin
                op         = OP_NBIS;
                state_next = flags.nb_in ? S_NBEV : S_NEXT;
            end
            S_NBEV:
                if (flags.nb_skip)
                    state_next = S_NEXT;
                else
                begin
                    op         = OP_NODE;
                    state_next = S_HW;
                end
            S_HW:
                if (flags.h_done)
                    state_next = S_PUSH;
            S_PUSH:
            begin
                op         = OP_PUSH;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                op         = OP_NEXT;
                state_next = flags.last_dir ? S_POPI : S_NBIS;
            end
            S_WST:
            begin
                op         = OP_WSTORE;
                state_next = flags.at_start ? S_DONE : S_WPAR;
            end
            S_WPAR:
            begin
                op         = OP_WPAR;
                state_next = flags.walk_end ? S_DONE : S_WST;
            end
            S_RDW:
            begin
                op         = OP_RDOUT;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                op         = OP_FINISH;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign done_next = (state_reg == S_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RCLR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done strobe longer than one cycle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result shown while busy");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted word did not start work");
    a_scan_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && flags.scan_end) |=> state_reg == S_POPMV)
        else $error("scan did not end in pop");

endmodule

@@ rtl/grid_astar_path_search_core.sv @@
// Grid A* path search on an 8-connected map of up to 64 x 64 cells. Raise
// start for one cycle while busy is low to issue a command word; exactly one
// result word follows, shown for one cycle with done high, and it must be
// captured then since the receiver cannot stall the block. After reset the
// obstacle map is cleared with busy high. A search first clears cell status,
// then for each expanded cell scans the open list one entry a cycle and
// visits 8 neighbors, computing a square-root heuristic for each one it
// pushes; the path walk stores each cell from the goal back to the start.
module grid_astar_path_search_core
    import gaps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  request_t   request,
    output logic       busy,
    output logic       done,
    output result_t    result,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);

    logic [OP_BITS-1:0] op;
    dp_status_t         flags;

    gaps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .op    (op),
        .busy  (busy),
        .done  (done)
    );

    gaps_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .request   (request),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .flags     (flags),
        .result    (result)
    );

endmodule
